// ===== hdl/asosc_pkg.sv =====
`timescale 1ns / 1ps

package asosc_pkg;

  localparam int HARMONIC_MAX_DEF     = 64;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;

  localparam int AMP_W   = 16;
  localparam int STEP_W  = 32;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 32;
  localparam int OUT_W   = 24;

  localparam logic [AMP_W-1:0]   AMP_RESET   = 16'd32768;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd0;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd50;

  localparam logic signed [23:0] INV_PI_Q24 = 24'sd5340353;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  typedef enum logic [1:0] {
    CFG_AMPLITUDE      = 2'd0,
    CFG_PHASE_STEP     = 2'd1,
    CFG_HARMONIC_COUNT = 2'd2
  } cfg_idx_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE    = 3'd0;
  localparam step_t STEP_MUL     = 3'd1;
  localparam step_t STEP_CHECK   = 3'd2;
  localparam step_t STEP_ISSUE   = 3'd3;
  localparam step_t STEP_DRAIN   = 3'd4;
  localparam step_t STEP_FIN_LO  = 3'd5;
  localparam step_t STEP_FIN_HI  = 3'd6;
  localparam step_t STEP_FIN_OUT = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE    = 3'd0,
    OP_MUL     = 3'd1,
    OP_NOP     = 3'd2,
    OP_ISSUE   = 3'd3,
    OP_FIN_LO  = 3'd4,
    OP_FIN_HI  = 3'd5,
    OP_FIN_OUT = 3'd6
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_NO_START    = 3'd1,
    C_MUL_MORE    = 3'd2,
    C_CNT_ZERO    = 3'd3,
    C_HARM_MORE   = 3'd4,
    C_PIPE_BUSY   = 3'd5,
    C_OUT_BLOCKED = 3'd6
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } cw_t;

  typedef struct packed {
    logic start;
    logic mul_more;
    logic cnt_zero;
    logic harm_more;
    logic pipe_busy;
    logic out_blocked;
  } stat_t;

  function automatic cw_t ucode(step_t s);
    cw_t w;
    unique case (s)
      STEP_IDLE:    w = '{op: OP_IDLE,    cond: C_NO_START,    target: STEP_IDLE};
      STEP_MUL:     w = '{op: OP_MUL,     cond: C_MUL_MORE,    target: STEP_MUL};
      STEP_CHECK:   w = '{op: OP_NOP,     cond: C_CNT_ZERO,    target: STEP_DRAIN};
      STEP_ISSUE:   w = '{op: OP_ISSUE,   cond: C_HARM_MORE,   target: STEP_ISSUE};
      STEP_DRAIN:   w = '{op: OP_NOP,     cond: C_PIPE_BUSY,   target: STEP_DRAIN};
      STEP_FIN_LO:  w = '{op: OP_FIN_LO,  cond: C_NEVER,       target: STEP_IDLE};
      STEP_FIN_HI:  w = '{op: OP_FIN_HI,  cond: C_NEVER,       target: STEP_IDLE};
      STEP_FIN_OUT: w = '{op: OP_FIN_OUT, cond: C_OUT_BLOCKED, target: STEP_FIN_OUT};
      default:      w = '{op: OP_NOP,     cond: C_NEVER,       target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/asosc_tick_if.sv =====
`timescale 1ns / 1ps

interface asosc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

// ===== hdl/asosc_sample_if.sv =====
`timescale 1ns / 1ps

interface asosc_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [asosc_pkg::OUT_W-1:0]    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hdl/additive_sawtooth_oscillator.sv =====
`timescale 1ns / 1ps

// Band-limited sawtooth oscillator built as a sum of sine harmonics. Every request
// with tick set produces one signed Q3.21 sample from the current phase, after which
// the phase advances by phase_step; a request with tick clear is taken and produces
// nothing. A request occupies the block while a small microprogram first forms phase
// times table depth by shift and add, then pushes one harmonic per cycle through the
// shared sine-lookup and level pipeline, and finishes with a two-part scaling by
// 1/pi. A finished sample waits in the output register while the next request is
// taken. Registers are to be written only while no request is in progress; the block
// itself does not enforce this.

module additive_sawtooth_oscillator #(
  parameter int HARMONIC_MAX     = asosc_pkg::HARMONIC_MAX_DEF,
  parameter int SINE_TABLE_DEPTH = asosc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = asosc_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  asosc_tick_if.sink                      in_chan,
  asosc_sample_if.source                  out_chan,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [asosc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(HARMONIC_MAX + 1);

  logic [asosc_pkg::AMP_W-1:0]   amplitude_r;
  logic [asosc_pkg::STEP_W-1:0]  phase_step_r;
  logic [asosc_pkg::COUNT_W-1:0] harm_count_r;
  logic [31:0]                   count_wide;
  logic [CNT_W-1:0]              count_eff;
  asosc_pkg::cw_t                cw;
  asosc_pkg::stat_t              stat;

  assign count_wide = 32'(harm_count_r);
  assign count_eff  = (count_wide > 32'(HARMONIC_MAX)) ? CNT_W'(HARMONIC_MAX)
                                                       : CNT_W'(count_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r  <= asosc_pkg::AMP_RESET;
      phase_step_r <= asosc_pkg::STEP_RESET;
      harm_count_r <= asosc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asosc_pkg::CFG_AMPLITUDE:      amplitude_r  <= cfg_data[asosc_pkg::AMP_W-1:0];
        asosc_pkg::CFG_PHASE_STEP:     phase_step_r <= cfg_data[asosc_pkg::STEP_W-1:0];
        asosc_pkg::CFG_HARMONIC_COUNT: harm_count_r <= cfg_data[asosc_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  asosc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  asosc_dp #(
    .HARMONIC_MAX     (HARMONIC_MAX),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cw         (cw),
    .stat       (stat),
    .amplitude  (amplitude_r),
    .phase_step (phase_step_r),
    .harm_count (count_eff)
  );

endmodule

// ===== hdl/asosc_useq.sv =====
`timescale 1ns / 1ps

module asosc_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  asosc_pkg::stat_t  stat,
  output asosc_pkg::cw_t    cw
);

  asosc_pkg::step_t step_r;
  asosc_pkg::step_t step_nxt;
  logic             jump;

  assign cw = asosc_pkg::ucode(step_r);

  always_comb begin
    unique case (cw.cond)
      asosc_pkg::C_NEVER:       jump = 1'b0;
      asosc_pkg::C_NO_START:    jump = !stat.start;
      asosc_pkg::C_MUL_MORE:    jump = stat.mul_more;
      asosc_pkg::C_CNT_ZERO:    jump = stat.cnt_zero;
      asosc_pkg::C_HARM_MORE:   jump = stat.harm_more;
      asosc_pkg::C_PIPE_BUSY:   jump = stat.pipe_busy;
      asosc_pkg::C_OUT_BLOCKED: jump = stat.out_blocked;
      default:                  jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= asosc_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hdl/asosc_sine.sv =====
`timescale 1ns / 1ps

module asosc_sine #(
  parameter int SINE_TABLE_DEPTH = asosc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
  input  logic [15:0]                         frac,
  output logic signed [16:0]                  sine
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH);

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic logic signed [15:0] rom_entry(int unsigned k);
    logic [63:0]        kk;
    logic [63:0]        t;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        a;
    logic [63:0]        s;
    logic [63:0]        v;
    logic [1:0]         q;
    logic signed [15:0] e;
    kk = 64'(k);
    t  = (kk << 32) / 64'(SINE_TABLE_DEPTH);
    q  = t[31:30];
    r  = {34'd0, t[29:0]};
    if (q[0]) begin
      r = (64'd1 << 30) - r;
    end
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    a  = (64'd1 << 30) - x2 / 64'd72;
    a  = (64'd1 << 30) - ((x2 * a) >> 30) / 64'd42;
    a  = (64'd1 << 30) - ((x2 * a) >> 30) / 64'd20;
    a  = (64'd1 << 30) - ((x2 * a) >> 30) / 64'd6;
    s  = (x * a) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    e = v[15:0];
    return q[1] ? -e : e;
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t tab;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      tab[k] = rom_entry(k);
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  logic [AW-1:0]      addr_nx;
  logic signed [15:0] lo_r;
  logic signed [15:0] hi_r;
  logic [15:0]        f_r;
  logic signed [16:0] diff;
  logic signed [33:0] dprod_r;
  logic signed [15:0] lo2_r;
  logic signed [33:0] rnd;
  logic signed [16:0] sine_r;

  assign addr_nx = (addr == AW'(SINE_TABLE_DEPTH - 1)) ? '0 : addr + AW'(1);
  assign diff    = 17'(hi_r) - 17'(lo_r);
  assign rnd     = dprod_r + 34'sd32768;
  assign sine    = sine_r;

  always_ff @(posedge clk) begin
    lo_r    <= SINE_ROM[addr];
    hi_r    <= SINE_ROM[addr_nx];
    f_r     <= frac;
    dprod_r <= diff * $signed({1'b0, f_r});
    lo2_r   <= lo_r;
    sine_r  <= 17'(lo2_r) + 17'(rnd >>> 16);
  end

endmodule

// ===== hdl/asosc_dp.sv =====
`timescale 1ns / 1ps

module asosc_dp #(
  parameter int HARMONIC_MAX     = asosc_pkg::HARMONIC_MAX_DEF,
  parameter int SINE_TABLE_DEPTH = asosc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = asosc_pkg::PHASE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  asosc_tick_if.sink                            in_chan,
  asosc_sample_if.source                        out_chan,
  input  asosc_pkg::cw_t                        cw,
  output asosc_pkg::stat_t                      stat,
  input  logic [asosc_pkg::AMP_W-1:0]           amplitude,
  input  logic [asosc_pkg::STEP_W-1:0]          phase_step,
  input  logic [$clog2(HARMONIC_MAX+1)-1:0]     harm_count
);

  localparam int AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int DB    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MC_W  = (DB > 1) ? $clog2(DB) : 1;
  localparam int CNT_W = $clog2(HARMONIC_MAX + 1);
  localparam int HM_W  = (HARMONIC_MAX > 1) ? $clog2(HARMONIC_MAX) : 1;
  localparam int WS_W  = PHASE_BITS + DB;
  localparam int ACC_W = 34 + HM_W;
  localparam int LO_W  = 21;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int P_W   = LO_W + 1 + 24;
  localparam int Q_W   = HI_W + 24;
  localparam int S_W   = ACC_W + 26;
  localparam int Y_W   = S_W - 33;

  localparam logic [DB-1:0]          DEPTH_V = DB'(SINE_TABLE_DEPTH);
  localparam logic signed [S_W-1:0]  RND_HALF = S_W'(1) <<< 32;
  localparam logic signed [Y_W-1:0]  Y_MAX = Y_W'(asosc_pkg::OUT_MAX);
  localparam logic signed [Y_W-1:0]  Y_MIN = Y_W'(asosc_pkg::OUT_MIN);

  typedef logic [16:0] recip_tab_t [HARMONIC_MAX];

  // Rounded 1/n in Q1.16, formed by restoring shift-and-subtract division.
  function automatic logic [16:0] recip_of(int unsigned n);
    logic [17:0] num;
    logic [17:0] den;
    logic [17:0] rem;
    logic [17:0] quo;
    num = 18'(131072 + n);
    den = 18'(2 * n);
    rem = '0;
    quo = '0;
    for (int b = 17; b >= 0; b--) begin
      rem = {rem[16:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo[16:0];
  endfunction

  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    for (int i = 0; i < HARMONIC_MAX; i++) begin
      tab[i] = recip_of(i + 1);
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = build_recip();

  logic [PHASE_BITS-1:0]     phase_r;
  logic [4:0]                v_r;
  logic                      out_valid_r;
  logic signed [23:0]        sample_r;

  logic [WS_W-1:0]           wstep_r;
  logic [MC_W-1:0]           mul_cnt_r;
  logic [CNT_W-1:0]          harm_left_r;
  logic [HM_W-1:0]           hidx_r;
  logic [HM_W-1:0]           h0_r;
  logic [AW-1:0]             idx_r;
  logic [PHASE_BITS-1:0]     frac_r;
  logic [32:0]               lvl_p_r;
  logic [15:0]               lvl_r;
  logic [15:0]               lvl3_r;
  logic signed [33:0]        term_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [P_W-1:0]     p_r;
  logic signed [Q_W-1:0]     q_r;

  logic                      start;
  logic                      blocked;
  logic                      fin_go;
  logic [WS_W-1:0]           wstep_nxt;
  logic [PHASE_BITS:0]       frac_sum;
  logic [DB:0]               idx_sum;
  logic [DB:0]               idx_wrap;
  logic [32:0]               lvl_sum;
  logic signed [16:0]        sine;
  logic signed [S_W-1:0]     fin_sum;
  logic signed [Y_W-1:0]     y;
  logic signed [23:0]        y_sat;

  asosc_sine #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk  (clk),
    .addr (idx_r),
    .frac (frac_r[PHASE_BITS-1 -: 16]),
    .sine (sine)
  );

  assign in_chan.ready       = (cw.op == asosc_pkg::OP_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = sample_r;

  assign start   = in_chan.valid && in_chan.ready && in_chan.tick;
  assign blocked = out_valid_r && !out_chan.ready;
  assign fin_go  = (cw.op == asosc_pkg::OP_FIN_OUT) && !blocked;

  assign stat.start       = start;
  assign stat.mul_more    = (mul_cnt_r != '0);
  assign stat.cnt_zero    = (harm_left_r == '0);
  assign stat.harm_more   = (harm_left_r != CNT_W'(1));
  assign stat.pipe_busy   = (v_r != '0);
  assign stat.out_blocked = blocked;

  always_comb begin
    wstep_nxt = (wstep_r << 1) + (DEPTH_V[mul_cnt_r] ? WS_W'(phase_r) : '0);
    frac_sum  = {1'b0, frac_r} + {1'b0, wstep_r[PHASE_BITS-1:0]};
    idx_sum   = (DB+1)'(idx_r) + (DB+1)'(wstep_r[WS_W-1:PHASE_BITS])
              + (DB+1)'(frac_sum[PHASE_BITS]);
    if (idx_sum >= (DB+1)'(SINE_TABLE_DEPTH)) begin
      idx_wrap = idx_sum - (DB+1)'(SINE_TABLE_DEPTH);
    end else begin
      idx_wrap = idx_sum;
    end
    lvl_sum = lvl_p_r + 33'd32768;
    fin_sum = (S_W'(q_r) <<< LO_W) + S_W'(p_r) + RND_HALF;
    y       = Y_W'(fin_sum >>> 33);
    if (y > Y_MAX) begin
      y_sat = 24'(Y_MAX);
    end else if (y < Y_MIN) begin
      y_sat = 24'(Y_MIN);
    end else begin
      y_sat = 24'(y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r <= {v_r[3:0], cw.op == asosc_pkg::OP_ISSUE};
      if (cw.op == asosc_pkg::OP_FIN_HI) begin
        phase_r <= phase_r + PHASE_BITS'(phase_step);
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h0_r    <= hidx_r;
    lvl_p_r <= 33'(amplitude) * 33'(RECIP[h0_r]);
    lvl_r   <= lvl_sum[31:16];
    lvl3_r  <= lvl_r;
    term_r  <= sine * $signed({1'b0, lvl3_r});
    if (v_r[4]) begin
      acc_r <= acc_r + ACC_W'(term_r);
    end
    unique case (cw.op)
      asosc_pkg::OP_IDLE: begin
        if (start) begin
          wstep_r     <= '0;
          mul_cnt_r   <= MC_W'(DB - 1);
          harm_left_r <= harm_count;
          hidx_r      <= '0;
          idx_r       <= '0;
          frac_r      <= '0;
          acc_r       <= '0;
        end
      end
      asosc_pkg::OP_MUL: begin
        wstep_r   <= wstep_nxt;
        mul_cnt_r <= mul_cnt_r - MC_W'(1);
      end
      asosc_pkg::OP_ISSUE: begin
        frac_r      <= frac_sum[PHASE_BITS-1:0];
        idx_r       <= AW'(idx_wrap);
        hidx_r      <= hidx_r + HM_W'(1);
        harm_left_r <= harm_left_r - CNT_W'(1);
      end
      asosc_pkg::OP_FIN_LO: begin
        p_r <= $signed({1'b0, acc_r[LO_W-1:0]}) * asosc_pkg::INV_PI_Q24;
      end
      asosc_pkg::OP_FIN_HI: begin
        q_r <= $signed(acc_r[ACC_W-1:LO_W]) * asosc_pkg::INV_PI_Q24;
      end
      asosc_pkg::OP_FIN_OUT: begin
        if (fin_go) begin
          sample_r <= y_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == asosc_pkg::OP_FIN_LO) |-> (v_r == '0))
    else $error("Harmonic pipeline not drained before the final scaling.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op != asosc_pkg::OP_FIN_HI) |=> $stable(phase_r))
    else $error("Phase moved outside the phase update step.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == asosc_pkg::OP_ISSUE) |-> (harm_left_r != '0))
    else $error("Harmonic issued with no harmonics left.");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (v_r == '0))
    else $error("Request taken while harmonics are still in flight.");

endmodule
